@@ hdl/chacc_pkg.sv @@
// Package for the calorimeter cell hit accumulator.
// Holds table sizing, entry and control types, status codes and the saturating add.
// No dependencies.
package chacc_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int CELL_ID_BITS = 16;
    localparam int CELL_W       = (CELL_ID_BITS < 16) ? CELL_ID_BITS : 16;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_ACCUM   = 3'd1,
        ST_NEW     = 3'd2,
        ST_FULL    = 3'd3,
        ST_FLUSHED = 3'd4,
        ST_EMPTY   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_FLUSH
    } t_state;

    typedef enum logic {
        OP_DEPOSIT = 1'b0,
        OP_FLUSH   = 1'b1
    } t_op;

    typedef struct packed {
        logic [CELL_W-1:0] cid;
        logic [31:0]       total;
        logic [31:0]       em;
        logic [31:0]       tm;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
    } t_entry;

    typedef struct packed {
        logic match;
        logic load;
        logic upd;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        t_status            status;
        logic [15:0]        cid;
        logic [31:0]        total;
        logic [31:0]        em;
        logic [31:0]        tm;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic [6:0]         count;
        logic               last;
    } t_result;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [23:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ hdl/chacc_if.sv @@
// Channel interfaces: deposit/flush input and result output, valid/ready.
// Depends on nothing.
interface chacc_dep_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [15:0]        cell_id;
    logic [23:0]        deposit_energy;
    logic               is_em;
    logic [31:0]        deposit_time;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;

    modport source (output valid, operation, cell_id, deposit_energy, is_em, deposit_time,
                    pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, operation, cell_id, deposit_energy, is_em, deposit_time,
                    pos_x, pos_y, pos_z, output ready);
endinterface

interface chacc_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        out_cell_id;
    logic [31:0]        total_energy;
    logic [31:0]        em_energy;
    logic [31:0]        first_time;
    logic signed [23:0] out_pos_x;
    logic signed [23:0] out_pos_y;
    logic signed [23:0] out_pos_z;
    logic [6:0]         entry_count;
    logic               last;

    modport source (output valid, status, out_cell_id, total_energy, em_energy, first_time,
                    out_pos_x, out_pos_y, out_pos_z, entry_count, last, input ready);
    modport sink   (input valid, status, out_cell_id, total_energy, em_energy, first_time,
                    out_pos_x, out_pos_y, out_pos_z, entry_count, last, output ready);
endinterface

@@ hdl/chacc_cell.sv @@
// One table cell: holds an entry, compares it against the broadcast key,
// takes updates, and shifts toward cell 0 on flush. Depends on chacc_pkg.
module chacc_cell import chacc_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_valid,
    input  logic [CELL_W-1:0] i_key,
    input  t_entry            i_new,
    input  t_entry            i_next,
    input  logic [31:0]       i_total,
    input  logic [31:0]       i_em,
    output t_entry            o_entry,
    output logic              o_hit
);

    t_entry r_entry;
    logic   r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.match) begin
            r_hit <= i_valid && (r_entry.cid == i_key);
        end
        if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.upd) begin
            r_entry.total <= i_total;
            r_entry.em    <= i_em;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

@@ hdl/calorimeter_cell_hit_accumulator_core.sv @@
// Top level of the calorimeter cell hit accumulator: control, shared adders, result register.
// Depends on chacc_pkg, chacc_dep_if, chacc_res_if and chacc_cell.
//
// Usage:
//   i_dep carries deposits (operation 0) and end-of-event flushes (operation 1).
//   o_res carries result transactions; last marks the final one caused by an input.
//   A deposit is matched against all cells in parallel in the cycle it is taken,
//   then the hit cell is updated through the shared saturating adders (total and
//   EM) in the update state, which also loads the result register; that step waits
//   while the result register still holds a result that o_res has not taken.
//   A flush shifts the row of cells toward cell 0 one entry per cycle while o_res
//   does not stall, giving one result per stored entry, or the empty marker if none.
//   The result register decouples the sides: when o_res stalls, the pending update or
//   flush step waits; the input is taken again only after the work of the previous
//   transaction has been placed in the result register.
//   Reset (i_rst_n low, synchronous) empties the table and drops any pending result;
//   cell contents are not cleared, only the entry count.
module calorimeter_cell_hit_accumulator_core import chacc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    chacc_dep_if.sink   i_dep,
    chacc_res_if.source o_res
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_ov, n_ov;
    t_result           r_out, n_out;

    logic              r_em;
    logic [23:0]       r_energy;
    logic [CELL_W-1:0] r_key;
    logic [31:0]       r_time;
    logic signed [23:0] r_px, r_py, r_pz;

    t_entry            entry [TABLE_DEPTH];
    t_entry            next_entry [TABLE_DEPTH];
    t_cell_ctl         ctl [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit;
    logic [TABLE_DEPTH-1:0] cell_valid;

    logic              accept;
    logic              out_free;
    logic              any_hit;
    t_entry            sel;
    t_entry            new_entry;
    logic [31:0]       sum_tot, sum_em;
    logic              do_update, do_new, do_shift;
    logic [CELL_W-1:0] in_key;

    assign accept   = i_dep.valid && i_dep.ready;
    assign out_free = !r_ov || o_res.ready;
    assign in_key   = i_dep.cell_id[CELL_W-1:0];

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            if (g == TABLE_DEPTH - 1) begin : g_end
                assign next_entry[g] = entry[g];
            end else begin : g_mid
                assign next_entry[g] = entry[g + 1];
            end
            assign cell_valid[g] = r_count > CNT_W'(g);
            assign ctl[g].match  = accept;
            assign ctl[g].load   = do_new && (r_count == CNT_W'(g));
            assign ctl[g].upd    = do_update && hit[g];
            assign ctl[g].shift  = do_shift;

            chacc_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl[g]),
                .i_valid (cell_valid[g]),
                .i_key   (in_key),
                .i_new   (new_entry),
                .i_next  (next_entry[g]),
                .i_total (sum_tot),
                .i_em    (sum_em),
                .o_entry (entry[g]),
                .o_hit   (hit[g])
            );
        end
    endgenerate

    always_comb begin
        sel = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (hit[k]) begin
                sel = sel | entry[k];
            end
        end
    end

    assign any_hit = |hit;
    assign sum_tot = sat_add(sel.total, r_energy);
    assign sum_em  = r_em ? sat_add(sel.em, r_energy) : sel.em;

    always_comb begin
        new_entry       = '0;
        new_entry.cid   = r_key;
        new_entry.total = 32'(r_energy);
        new_entry.em    = r_em ? 32'(r_energy) : 32'd0;
        new_entry.tm    = r_time;
        new_entry.px    = r_px;
        new_entry.py    = r_py;
        new_entry.pz    = r_pz;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_em     <= i_dep.is_em;
            r_energy <= i_dep.deposit_energy;
            r_key    <= in_key;
            r_time   <= i_dep.deposit_time;
            r_px     <= i_dep.pos_x;
            r_py     <= i_dep.pos_y;
            r_pz     <= i_dep.pos_z;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_ov      = r_ov && !o_res.ready;
        n_out     = r_out;
        do_update = 1'b0;
        do_new    = 1'b0;
        do_shift  = 1'b0;
        i_dep.ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_left  = r_count;
                    n_state = (t_op'(i_dep.operation) == OP_FLUSH) ? S_FLUSH : S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_state    = S_IDLE;
                    n_out      = '0;
                    n_out.cid  = 16'(r_key);
                    n_out.last = 1'b1;
                    if (r_energy == '0) begin
                        n_out.status = ST_IGNORED;
                    end else if (any_hit) begin
                        do_update    = 1'b1;
                        n_out.status = ST_ACCUM;
                        n_out.cid    = 16'(sel.cid);
                        n_out.total  = sum_tot;
                        n_out.em     = sum_em;
                        n_out.tm     = sel.tm;
                        n_out.px     = sel.px;
                        n_out.py     = sel.py;
                        n_out.pz     = sel.pz;
                    end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        do_new       = 1'b1;
                        n_count      = r_count + 1'b1;
                        n_out.status = ST_NEW;
                        n_out.total  = new_entry.total;
                        n_out.em     = new_entry.em;
                        n_out.tm     = r_time;
                        n_out.px     = r_px;
                        n_out.py     = r_py;
                        n_out.pz     = r_pz;
                    end
                    n_out.count = 7'(n_count);
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = '0;
                    if (r_count == '0) begin
                        n_out.status = ST_EMPTY;
                        n_out.last   = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        do_shift     = 1'b1;
                        n_out.status = ST_FLUSHED;
                        n_out.cid    = 16'(entry[0].cid);
                        n_out.total  = entry[0].total;
                        n_out.em     = entry[0].em;
                        n_out.tm     = entry[0].tm;
                        n_out.px     = entry[0].px;
                        n_out.py     = entry[0].py;
                        n_out.pz     = entry[0].pz;
                        n_out.count  = 7'(r_count);
                        n_out.last   = (r_left == CNT_W'(1));
                        n_left       = r_left - 1'b1;
                        if (r_left == CNT_W'(1)) begin
                            n_count = '0;
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.valid        = r_ov;
    assign o_res.status       = r_out.status;
    assign o_res.out_cell_id  = r_out.cid;
    assign o_res.total_energy = r_out.total;
    assign o_res.em_energy    = r_out.em;
    assign o_res.first_time   = r_out.tm;
    assign o_res.out_pos_x    = r_out.px;
    assign o_res.out_pos_y    = r_out.py;
    assign o_res.out_pos_z    = r_out.pz;
    assign o_res.entry_count  = r_out.count;
    assign o_res.last         = r_out.last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> $onehot0(hit))
        else $error("cell matched in more than one table entry");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && out_free && r_out.last == 1'b0 && n_out.last) |=> r_count == '0)
        else $error("table not cleared after flush");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_dep.ready)
        else $error("input taken again before previous transaction was processed");

endmodule

@@ tb/sv/tb_calorimeter_cell_hit_accumulator_core.sv @@
// Testbench for calorimeter_cell_hit_accumulator_core: directed and random deposit/flush
// traffic with random idling on both channels, checked against a cell-table predictor.
// Depends on chacc_pkg, chacc_dep_if, chacc_res_if and the core.
module tb_calorimeter_cell_hit_accumulator_core;
    import chacc_pkg::*;

    localparam int MAX_IDLE     = 12;
    localparam int RANDOM_ITEMS = 40;

    typedef struct {
        t_op                op;
        logic [15:0]        cid;
        logic [23:0]        energy;
        logic               em;
        logic [31:0]        tm;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
    } t_hit;

    logic i_clk;
    logic i_rst_n;

    chacc_dep_if dep_ch ();
    chacc_res_if res_ch ();

    calorimeter_cell_hit_accumulator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dep   (dep_ch),
        .o_res   (res_ch)
    );

    // cell table as the block should hold it
    int                 cells_used;
    logic [15:0]        cell_id_tbl [TABLE_DEPTH];
    logic [31:0]        total_tbl   [TABLE_DEPTH];
    logic [31:0]        em_tbl      [TABLE_DEPTH];
    logic [31:0]        time_tbl    [TABLE_DEPTH];
    logic signed [23:0] px_tbl      [TABLE_DEPTH];
    logic signed [23:0] py_tbl      [TABLE_DEPTH];
    logic signed [23:0] pz_tbl      [TABLE_DEPTH];

    t_result results_due[$];
    int      mismatch_count;
    int      src_gap_max;
    int      sink_stall_max;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_calorimeter_cell_hit_accumulator_core failed");
        $finish;
    end

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [23:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_result table_row(input t_status st, input int i, input logic lst);
        t_result r;
        r.status = st;
        r.cid    = cell_id_tbl[i];
        r.total  = total_tbl[i];
        r.em     = em_tbl[i];
        r.tm     = time_tbl[i];
        r.px     = px_tbl[i];
        r.py     = py_tbl[i];
        r.pz     = pz_tbl[i];
        r.count  = 7'(cells_used);
        r.last   = lst;
        return r;
    endfunction

    function automatic t_result bare_result(input t_status st, input logic [15:0] c);
        t_result r;
        r        = '0;
        r.status = st;
        r.cid    = c;
        r.count  = 7'(cells_used);
        r.last   = 1'b1;
        return r;
    endfunction

    task automatic accumulate_hit(input t_hit h);
        logic [15:0] key;
        int          hit_idx;
        key     = h.cid & 16'((33'd1 << CELL_ID_BITS) - 33'd1);
        hit_idx = -1;
        if (h.op == OP_FLUSH) begin
            if (cells_used == 0) begin
                results_due.push_back(bare_result(ST_EMPTY, 16'd0));
            end else begin
                for (int i = 0; i < cells_used; i++)
                    results_due.push_back(table_row(ST_FLUSHED, i, i == cells_used - 1));
                cells_used = 0;
            end
        end else if (h.energy == 24'd0) begin
            results_due.push_back(bare_result(ST_IGNORED, key));
        end else begin
            for (int i = 0; i < cells_used; i++)
                if (hit_idx < 0 && cell_id_tbl[i] == key) hit_idx = i;
            if (hit_idx >= 0) begin
                total_tbl[hit_idx] = add_clamped(total_tbl[hit_idx], h.energy);
                if (h.em) em_tbl[hit_idx] = add_clamped(em_tbl[hit_idx], h.energy);
                results_due.push_back(table_row(ST_ACCUM, hit_idx, 1'b1));
            end else if (cells_used >= TABLE_DEPTH) begin
                results_due.push_back(bare_result(ST_FULL, key));
            end else begin
                cell_id_tbl[cells_used] = key;
                total_tbl[cells_used]   = {8'd0, h.energy};
                em_tbl[cells_used]      = h.em ? {8'd0, h.energy} : 32'd0;
                time_tbl[cells_used]    = h.tm;
                px_tbl[cells_used]      = h.px;
                py_tbl[cells_used]      = h.py;
                pz_tbl[cells_used]      = h.pz;
                cells_used++;
                results_due.push_back(table_row(ST_NEW, cells_used - 1, 1'b1));
            end
        end
    endtask

    // called at a falling edge with valid low; returns the same way
    task automatic send_hit(input t_hit h);
        repeat ($urandom_range(src_gap_max, 0)) @(negedge i_clk);
        dep_ch.operation      = h.op;
        dep_ch.cell_id        = h.cid;
        dep_ch.deposit_energy = h.energy;
        dep_ch.is_em          = h.em;
        dep_ch.deposit_time   = h.tm;
        dep_ch.pos_x          = h.px;
        dep_ch.pos_y          = h.py;
        dep_ch.pos_z          = h.pz;
        dep_ch.valid          = 1'b1;
        @(posedge i_clk);
        while (!dep_ch.ready) @(posedge i_clk);
        accumulate_hit(h);
        @(negedge i_clk);
        dep_ch.valid = 1'b0;
    endtask

    function automatic t_hit random_hit();
        t_hit h;
        h.op   = OP_DEPOSIT;
        h.cid  = 16'($urandom);
        case ($urandom_range(9, 0))
            0:       h.energy = 24'd0;
            1, 2:    h.energy = 24'hFF_FFFF - 24'($urandom_range(255, 0));
            3, 4, 5: h.energy = 24'($urandom_range(255, 1));
            default: h.energy = 24'($urandom);
        endcase
        h.em = 1'($urandom);
        h.tm = $urandom;
        h.px = 24'($urandom);
        h.py = 24'($urandom);
        h.pz = 24'($urandom);
        return h;
    endfunction

    function automatic t_hit flush_hit();
        t_hit h;
        h    = random_hit();
        h.op = OP_FLUSH;
        return h;
    endfunction

    task automatic wait_results_drained();
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (results_due.size() == 0) begin
            $error("result transaction with none expected: status %0d cell %0h",
                   res_ch.status, res_ch.out_cell_id);
            mismatch_count++;
        end else begin
            want = results_due.pop_front();
            cmp_field("status", 32'(want.status), 32'(res_ch.status));
            cmp_field("out_cell_id", 32'(want.cid), 32'(res_ch.out_cell_id));
            cmp_field("total_energy", want.total, res_ch.total_energy);
            cmp_field("em_energy", want.em, res_ch.em_energy);
            cmp_field("first_time", want.tm, res_ch.first_time);
            cmp_field("out_pos_x", 32'(want.px), 32'(res_ch.out_pos_x));
            cmp_field("out_pos_y", 32'(want.py), 32'(res_ch.out_pos_y));
            cmp_field("out_pos_z", 32'(want.pz), 32'(res_ch.out_pos_z));
            cmp_field("entry_count", 32'(want.count), 32'(res_ch.entry_count));
            cmp_field("last", 32'(want.last), 32'(res_ch.last));
        end
    endtask

    // result sink: random stall before each transaction, check on acceptance
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            repeat ($urandom_range(sink_stall_max, 0)) @(negedge i_clk);
            res_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!(i_rst_n && res_ch.valid === 1'b1)) @(posedge i_clk);
            check_result();
            @(negedge i_clk);
            res_ch.ready = 1'b0;
        end
    end

    task automatic test_field_extremes();
        t_hit h;
        send_hit(flush_hit());
        h        = random_hit();
        h.cid    = 16'hFFFF;
        h.energy = 24'd0;
        h.em     = 1'b1;
        h.tm     = 32'hFFFF_FFFF;
        h.px     = 24'hFF_FFFF;
        h.py     = 24'hFF_FFFF;
        h.pz     = 24'hFF_FFFF;
        send_hit(h);
        h.energy = 24'd1;
        h.em     = 1'b0;
        h.px     = 24'h7F_FFFF;
        h.py     = 24'h7F_FFFF;
        h.pz     = 24'h7F_FFFF;
        send_hit(h);
        h.cid    = 16'h0000;
        h.energy = 24'hFF_FFFF;
        h.em     = 1'b1;
        h.tm     = 32'd0;
        h.px     = 24'h80_0000;
        h.py     = 24'h80_0000;
        h.pz     = 24'h80_0000;
        send_hit(h);
        h        = random_hit();
        h.cid    = 16'hFFFF;
        h.energy = 24'hFF_FFFF;
        h.em     = 1'b1;
        send_hit(h);
        h        = random_hit();
        h.cid    = 16'h0000;
        h.energy = 24'd0;
        send_hit(h);
        h.cid    = 16'h5555;
        h.energy = 24'hAA_AAAA;
        h.em     = 1'b0;
        h.tm     = 32'h5555_5555;
        h.px     = 24'h55_5555;
        h.py     = 24'hAA_AAAA;
        h.pz     = 24'h55_5555;
        send_hit(h);
        h.cid    = 16'hAAAA;
        h.energy = 24'h55_5555;
        h.em     = 1'b1;
        h.tm     = 32'hAAAA_AAAA;
        h.px     = 24'hAA_AAAA;
        h.py     = 24'h55_5555;
        h.pz     = 24'hAA_AAAA;
        send_hit(h);
        h.cid    = 16'h5555;
        h.energy = 24'd1;
        send_hit(h);
        send_hit(flush_hit());
        send_hit(flush_hit());
    endtask

    task automatic test_table_full();
        t_hit        h;
        logic [15:0] base;
        base = 16'($urandom);
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            h      = random_hit();
            h.cid  = base + 16'(k);
            if (h.energy == 24'd0) h.energy = 24'd7;
            send_hit(h);
        end
        h        = random_hit();
        h.cid    = base + 16'(TABLE_DEPTH);
        h.energy = 24'h00_1234;
        send_hit(h);
        h.energy = 24'd0;
        send_hit(h);
        h.cid    = base + 16'($urandom_range(TABLE_DEPTH - 1, 0));
        h.energy = 24'h80_0000;
        h.em     = 1'b1;
        send_hit(h);
        send_hit(flush_hit());
    endtask

    task automatic test_drain_pause();
        t_hit h;
        for (int k = 0; k < 4; k++) begin
            h      = random_hit();
            h.cid  = 16'(k * 3);
            send_hit(h);
        end
        wait_results_drained();
        send_hit(flush_hit());
        wait_results_drained();
        send_hit(flush_hit());
    endtask

    task automatic test_random_events();
        int          sent;
        int          pool_n;
        int          n_dep;
        logic [15:0] pool [8];
        t_hit        h;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            src_gap_max    = ($urandom_range(3, 0) == 0) ? 0 : MAX_IDLE;
            sink_stall_max = ($urandom_range(3, 0) == 0) ? 0 : MAX_IDLE;
            pool_n = $urandom_range(8, 1);
            for (int k = 0; k < pool_n; k++) pool[k] = 16'($urandom);
            n_dep = $urandom_range(12, 1);
            for (int k = 0; k < n_dep; k++) begin
                h = random_hit();
                if ($urandom_range(4, 0) != 0) h.cid = pool[$urandom_range(pool_n - 1, 0)];
                send_hit(h);
                sent++;
            end
            send_hit(flush_hit());
            sent++;
            if ($urandom_range(4, 0) == 0) begin
                send_hit(flush_hit());
                sent++;
            end
        end
        src_gap_max    = MAX_IDLE;
        sink_stall_max = MAX_IDLE;
    endtask

    initial begin
        mismatch_count        = 0;
        cells_used            = 0;
        src_gap_max           = MAX_IDLE;
        sink_stall_max        = MAX_IDLE;
        i_rst_n               = 1'b0;
        dep_ch.valid          = 1'b0;
        dep_ch.operation      = OP_DEPOSIT;
        dep_ch.cell_id        = '0;
        dep_ch.deposit_energy = '0;
        dep_ch.is_em          = 1'b0;
        dep_ch.deposit_time   = '0;
        dep_ch.pos_x          = '0;
        dep_ch.pos_y          = '0;
        dep_ch.pos_z          = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_field_extremes();
        test_table_full();
        test_drain_pause();
        test_random_events();

        wait_results_drained();
        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("tb_calorimeter_cell_hit_accumulator_core passed");
        end else begin
            $display("tb_calorimeter_cell_hit_accumulator_core failed");
        end
        $finish;
    end

endmodule
